// File: rtl/core/barometer_pressure_compensation_defines.svh
// assertion macros shared by the pressure compensation rtl
// no dependencies; included by the modules that carry assertions
`ifndef BAROMETER_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETER_PRESSURE_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every edge outside reset
`define BPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition now implies a result in the next cycle
`define BPC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BPC_ASSERT(label, clk, rst, prop, msg)
`define BPC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: rtl/core/bpc_pkg.sv
// shared types, widths and constants of the pressure compensation pipeline
// no dependencies; used by every module of the block
package bpc_pkg;

   // field widths
   localparam int CAL_W      = 16;
   localparam int RAW_W      = 24;
   localparam int TEMP_OUT_W = 16;
   localparam int PRESS_W    = 18;
   localparam int CSR_IDX_W  = 3;

   // scaling shifts of the compensation formulas
   localparam int REF_SHIFT      = 8;
   localparam int SLOPE_SHIFT    = 23;
   localparam int OFF_TC_SHIFT   = 7;
   localparam int SENS_TC_SHIFT  = 8;
   localparam int T2_SHIFT       = 31;
   localparam int OFF_CAL_SHIFT  = 16;
   localparam int SENS_CAL_SHIFT = 15;
   localparam int PRESS_SHIFT_HI = 21;
   localparam int PRESS_SHIFT_LO = 15;

   // internal widths
   localparam int DT_W      = RAW_W + 1;
   localparam int MUL_W     = DT_W + CAL_W + 1;
   localparam int DELTA_W   = MUL_W - SLOPE_SHIFT;
   localparam int TEMP_W    = DELTA_W + 1;
   localparam int DV_W      = DELTA_W + 1;
   localparam int SQDT_W    = 2 * DT_W;
   localparam int T2_W      = SQDT_W - 1 - T2_SHIFT;
   localparam int OFF_W     = 42;
   localparam int SENS_W    = 40;
   localparam int SQ_W      = 36;
   localparam int CORR_W    = 40;
   localparam int SENS_LO_W = 20;
   localparam int SENS_HI_W = SENS_W - SENS_LO_W;
   localparam int PL_W      = RAW_W + SENS_LO_W;
   localparam int PH_W      = RAW_W + 1 + SENS_HI_W;
   localparam int PROD_W    = 64;
   localparam int Q_W       = PROD_W - PRESS_SHIFT_HI;
   localparam int DIFF_W    = Q_W + 2;

   // temperature thresholds in hundredths of a degree
   localparam int TEMP_REF_CENTI      = 2000;
   localparam int TEMP_VERY_LOW_CENTI = -1500;
   localparam int PRESS_MAX           = 2 ** PRESS_W - 1;

   // calibration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS_CAL   = 3'd0,
      CSR_OFF_CAL    = 3'd1,
      CSR_SENS_TC    = 3'd2,
      CSR_OFF_TC     = 3'd3,
      CSR_REF_TEMP   = 3'd4,
      CSR_TEMP_SLOPE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity_cal;
      logic [CAL_W-1:0] pressure_offset_cal;
      logic [CAL_W-1:0] sensitivity_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature_cal;
      logic [CAL_W-1:0] temperature_slope_cal;
   } cal_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_OUT_W-1:0] temperature_centi;
      logic [PRESS_W-1:0]           pressure_pa;
      logic                         low_temp_applied;
      logic                         saturated;
   } rsp_type;

   // first-order terms handed from the temperature stages to the correction stages
   typedef struct packed {
      logic [RAW_W-1:0]          raw_pressure;
      logic signed [DELTA_W-1:0] delta;
      logic signed [DV_W-1:0]    dv;
      logic signed [TEMP_W-1:0]  temp1;
      logic [T2_W-1:0]           t2;
      logic                      low;
      logic                      vlow;
      logic signed [OFF_W-1:0]   off1;
      logic signed [SENS_W-1:0]  sens1;
   } tmp_type;

   // corrected terms handed to the pressure stages
   typedef struct packed {
      logic [RAW_W-1:0]         raw_pressure;
      logic signed [TEMP_W-1:0] temp_f;
      logic                     low;
      logic signed [OFF_W-1:0]  off_f;
      logic signed [SENS_W-1:0] sens_f;
   } corr_type;

endpackage

// File: rtl/core/barometer_pressure_compensation.sv
// a result passes registered stages s0 through s9 in order before it is presented
// throughput: one transfer per cycle while the output is not stalled; every stage holds its own valid bit
// the multipliers of the first-order, square and pressure stages set the stage count
// a stalled output only halts stages up to the first empty one
// reset (synchronous) clears all valid bits and the six calibration registers
// depends on bpc_pkg, bpc_temp_stage, bpc_corr_stage, bpc_press_stage
`include "barometer_pressure_compensation_defines.svh"

module barometer_pressure_compensation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CAL_W-1:0]       csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bpc_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bpc_pkg::rsp_type                rsp_payload
);

   bpc_pkg::cal_type  cal_in, cal_ff;
   logic              tmp_valid, tmp_stall;
   bpc_pkg::tmp_type  tmp_data;
   logic              corr_valid, corr_stall;
   bpc_pkg::corr_type corr_data;

   // calibration register writes, unknown indexes ignored
   always_comb begin
      cal_in = cal_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            bpc_pkg::CSR_SENS_CAL:   cal_in.pressure_sensitivity_cal  = csr_write_data;
            bpc_pkg::CSR_OFF_CAL:    cal_in.pressure_offset_cal       = csr_write_data;
            bpc_pkg::CSR_SENS_TC:    cal_in.sensitivity_temp_coeff    = csr_write_data;
            bpc_pkg::CSR_OFF_TC:     cal_in.offset_temp_coeff         = csr_write_data;
            bpc_pkg::CSR_REF_TEMP:   cal_in.reference_temperature_cal = csr_write_data;
            bpc_pkg::CSR_TEMP_SLOPE: cal_in.temperature_slope_cal     = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // first-order temperature, offset and sensitivity
   bpc_temp_stage u_temp (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_payload),
      .out_valid (tmp_valid),
      .out_stall (tmp_stall),
      .out_data  (tmp_data)
   );

   // second-order low-temperature correction
   bpc_corr_stage u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tmp_valid),
      .in_stall  (tmp_stall),
      .in_data   (tmp_data),
      .out_valid (corr_valid),
      .out_stall (corr_stall),
      .out_data  (corr_data)
   );

   // pressure, clamping and output register
   bpc_press_stage u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (corr_valid),
      .in_stall  (corr_stall),
      .in_data   (corr_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

   `BPC_ASSERT(a_empty_output_takes_input, clock, reset, !rsp_valid |-> !req_stall, "input stalled while output register is empty")

endmodule

// File: rtl/core/bpc_temp_stage.sv
// three stages: temperature difference, first-order products, first-order terms
// depends on bpc_pkg and the assertion macro header
`include "barometer_pressure_compensation_defines.svh"

module bpc_temp_stage (
   input  logic              clock,
   input  logic              reset,
   input  bpc_pkg::cal_type  cal,
   input  logic              in_valid,
   output logic              in_stall,
   input  bpc_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output bpc_pkg::tmp_type  out_data
);

   logic s0_en, s1_en, s2_en;
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff;

   logic signed [bpc_pkg::DT_W-1:0]   s0_dt_in, s0_dt_ff;
   logic [bpc_pkg::RAW_W-1:0]         s0_press_ff;
   logic [bpc_pkg::RAW_W-1:0]         s1_press_ff;
   logic signed [bpc_pkg::MUL_W-1:0]  s1_slope_in, s1_slope_ff;
   logic signed [bpc_pkg::MUL_W-1:0]  s1_off_in, s1_off_ff;
   logic signed [bpc_pkg::MUL_W-1:0]  s1_sens_in, s1_sens_ff;
   logic signed [bpc_pkg::SQDT_W-1:0] s1_sq_in, s1_sq_ff;
   logic signed [bpc_pkg::DELTA_W-1:0] s2_delta;
   bpc_pkg::tmp_type                  s2_data_in, s2_data_ff;

   // a stage loads when empty or when the next one moves
   assign s2_en    = !s2_valid_ff || !out_stall;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign s0_en    = !s0_valid_ff || s1_en;
   assign in_stall = !s0_en;

   // temperature difference against the reference word
   assign s0_dt_in = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cal.reference_temperature_cal,
                              {bpc_pkg::REF_SHIFT{1'b0}}});

   // first-order products and the square of the difference
   always_comb begin
      s1_slope_in = s0_dt_ff * $signed({1'b0, cal.temperature_slope_cal});
      s1_off_in   = s0_dt_ff * $signed({1'b0, cal.offset_temp_coeff});
      s1_sens_in  = s0_dt_ff * $signed({1'b0, cal.sensitivity_temp_coeff});
      s1_sq_in    = s0_dt_ff * s0_dt_ff;
   end

   // first-order temperature, offset and sensitivity
   assign s2_delta = s1_slope_ff[bpc_pkg::MUL_W-1:bpc_pkg::SLOPE_SHIFT];

   always_comb begin
      s2_data_in.raw_pressure = s1_press_ff;
      s2_data_in.delta        = s2_delta;
      s2_data_in.dv           = bpc_pkg::DV_W'(s2_delta)
                              + bpc_pkg::DV_W'(bpc_pkg::TEMP_REF_CENTI
                                               - bpc_pkg::TEMP_VERY_LOW_CENTI);
      s2_data_in.temp1        = bpc_pkg::TEMP_W'(s2_delta)
                              + bpc_pkg::TEMP_W'(bpc_pkg::TEMP_REF_CENTI);
      s2_data_in.low          = s2_delta[bpc_pkg::DELTA_W-1];
      s2_data_in.vlow         = s2_delta < bpc_pkg::DELTA_W'(bpc_pkg::TEMP_VERY_LOW_CENTI
                                                            - bpc_pkg::TEMP_REF_CENTI);
      s2_data_in.t2           = s2_delta[bpc_pkg::DELTA_W-1]
                              ? s1_sq_ff[bpc_pkg::SQDT_W-2:bpc_pkg::T2_SHIFT]
                              : '0;
      s2_data_in.off1         = $signed(bpc_pkg::OFF_W'({cal.pressure_offset_cal,
                                                         {bpc_pkg::OFF_CAL_SHIFT{1'b0}}}))
                              + bpc_pkg::OFF_W'($signed(
                                   s1_off_ff[bpc_pkg::MUL_W-1:bpc_pkg::OFF_TC_SHIFT]));
      s2_data_in.sens1        = $signed(bpc_pkg::SENS_W'({cal.pressure_sensitivity_cal,
                                                          {bpc_pkg::SENS_CAL_SHIFT{1'b0}}}))
                              + bpc_pkg::SENS_W'($signed(
                                   s1_sens_ff[bpc_pkg::MUL_W-1:bpc_pkg::SENS_TC_SHIFT]));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_en) s0_valid_ff <= in_valid;
         if (s1_en) s1_valid_ff <= s0_valid_ff;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_dt_ff    <= s0_dt_in;
         s0_press_ff <= in_data.raw_pressure;
      end
      if (s1_en) begin
         s1_press_ff <= s0_press_ff;
         s1_slope_ff <= s1_slope_in;
         s1_off_ff   <= s1_off_in;
         s1_sens_ff  <= s1_sens_in;
         s1_sq_ff    <= s1_sq_in;
      end
      if (s2_en) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

   `BPC_ASSERT(a_vlow_implies_low, clock, reset, s2_valid_ff && s2_data_ff.vlow |-> s2_data_ff.low, "very low correction flagged without low correction")

endmodule

// File: rtl/core/bpc_corr_stage.sv
// three stages of the second-order low-temperature correction
// depends on bpc_pkg and the assertion macro header
`include "barometer_pressure_compensation_defines.svh"

module bpc_corr_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  bpc_pkg::tmp_type  in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output bpc_pkg::corr_type out_data
);

   logic s3_en, s4_en, s5_en;
   logic s3_valid_ff, s4_valid_ff, s5_valid_ff;

   logic signed [2*bpc_pkg::DELTA_W-1:0] f1_full;
   logic signed [2*bpc_pkg::DV_W-1:0]    f2_full;
   logic [bpc_pkg::SQ_W-1:0]             s3_f1_ff, s3_f2_ff;
   bpc_pkg::tmp_type                     s3_data_ff, s4_data_ff;
   logic [bpc_pkg::CORR_W-1:0]           f1_ext, f2_ext;
   logic [bpc_pkg::CORR_W-1:0]           s4_c5_in, s4_c5_ff;
   logic [bpc_pkg::CORR_W-1:0]           s4_c7_in, s4_c7_ff;
   logic [bpc_pkg::CORR_W-1:0]           s4_c11_in, s4_c11_ff;
   logic signed [bpc_pkg::TEMP_W-1:0]    s4_temp_in, s4_temp_ff;
   bpc_pkg::corr_type                    s5_data_in, s5_data_ff;

   // stall chain
   assign s5_en    = !s5_valid_ff || !out_stall;
   assign s4_en    = !s4_valid_ff || s5_en;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_stall = !s3_en;

   // squares of the two temperature distances
   assign f1_full = in_data.delta * in_data.delta;
   assign f2_full = in_data.dv * in_data.dv;

   // scaled correction terms, zero where the range does not apply
   assign f1_ext = bpc_pkg::CORR_W'(s3_f1_ff);
   assign f2_ext = bpc_pkg::CORR_W'(s3_f2_ff);

   always_comb begin
      s4_c5_in   = s3_data_ff.low  ? f1_ext + (f1_ext << 2) : '0;
      s4_c7_in   = s3_data_ff.vlow ? (f2_ext << 3) - f2_ext : '0;
      s4_c11_in  = s3_data_ff.vlow ? (f2_ext << 3) + (f2_ext << 1) + f2_ext : '0;
      s4_temp_in = s3_data_ff.temp1 - $signed(bpc_pkg::TEMP_W'(s3_data_ff.t2));
   end

   // corrected offset and sensitivity
   always_comb begin
      s5_data_in.raw_pressure = s4_data_ff.raw_pressure;
      s5_data_in.temp_f       = s4_temp_ff;
      s5_data_in.low          = s4_data_ff.low;
      s5_data_in.off_f        = s4_data_ff.off1
                              - $signed(bpc_pkg::OFF_W'(s4_c5_ff >> 1))
                              - $signed(bpc_pkg::OFF_W'(s4_c7_ff));
      s5_data_in.sens_f       = s4_data_ff.sens1
                              - $signed(bpc_pkg::SENS_W'(s4_c5_ff >> 2))
                              - $signed(bpc_pkg::SENS_W'(s4_c11_ff >> 1));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_en) s3_valid_ff <= in_valid;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_f1_ff   <= f1_full[bpc_pkg::SQ_W-1:0];
         s3_f2_ff   <= f2_full[bpc_pkg::SQ_W-1:0];
         s3_data_ff <= in_data;
      end
      if (s4_en) begin
         s4_c5_ff   <= s4_c5_in;
         s4_c7_ff   <= s4_c7_in;
         s4_c11_ff  <= s4_c11_in;
         s4_temp_ff <= s4_temp_in;
         s4_data_ff <= s3_data_ff;
      end
      if (s5_en) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_data_ff;

   `BPC_ASSERT_NEXT(a_warm_no_corr, clock, reset, s4_en && s3_valid_ff && !s3_data_ff.low, s4_c5_ff == '0 && s4_c7_ff == '0 && s4_c11_ff == '0, "correction terms nonzero above reference temperature")

endmodule

// File: rtl/core/bpc_press_stage.sv
// four stages: split pressure product, recombine, offset subtract, clamp
// depends on bpc_pkg and the assertion macro header
`include "barometer_pressure_compensation_defines.svh"

module bpc_press_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  bpc_pkg::corr_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output bpc_pkg::rsp_type  out_data
);

   localparam int P_TOP = bpc_pkg::PRESS_SHIFT_LO + bpc_pkg::PRESS_W;

   logic s6_en, s7_en, s8_en, s9_en;
   logic s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;

   logic [bpc_pkg::PL_W-1:0]          s6_pl_in, s6_pl_ff;
   logic signed [bpc_pkg::PH_W-1:0]   s6_ph_in, s6_ph_ff;
   bpc_pkg::corr_type                 s6_data_ff, s7_data_ff, s8_data_ff;
   logic [bpc_pkg::PROD_W-1:0]        s7_prod_in, s7_prod_ff;
   logic signed [bpc_pkg::DIFF_W-1:0] s8_diff_in, s8_diff_ff;
   logic                              p_neg, p_over, t_ok, t_neg;
   logic [bpc_pkg::TEMP_W-bpc_pkg::TEMP_OUT_W:0] t_top;
   bpc_pkg::rsp_type                  s9_rsp_in, s9_rsp_ff;

   // stall chain, output register last
   assign s9_en    = !s9_valid_ff || !out_stall;
   assign s8_en    = !s8_valid_ff || s9_en;
   assign s7_en    = !s7_valid_ff || s8_en;
   assign s6_en    = !s6_valid_ff || s7_en;
   assign in_stall = !s6_en;

   // raw pressure times sensitivity as two partial products
   always_comb begin
      s6_pl_in = in_data.raw_pressure * in_data.sens_f[bpc_pkg::SENS_LO_W-1:0];
      s6_ph_in = $signed({1'b0, in_data.raw_pressure})
               * $signed(in_data.sens_f[bpc_pkg::SENS_W-1:bpc_pkg::SENS_LO_W]);
   end

   // recombine the partial products
   assign s7_prod_in = bpc_pkg::PROD_W'({s6_ph_ff, {bpc_pkg::SENS_LO_W{1'b0}}})
                     + bpc_pkg::PROD_W'(s6_pl_ff);

   // scaled product minus offset
   assign s8_diff_in = bpc_pkg::DIFF_W'($signed(
                          s7_prod_ff[bpc_pkg::PROD_W-1:bpc_pkg::PRESS_SHIFT_HI]))
                     - bpc_pkg::DIFF_W'(s7_data_ff.off_f);

   // clamp pressure and temperature to the output ranges
   assign p_neg  = s8_diff_ff[bpc_pkg::DIFF_W-1];
   assign p_over = !p_neg && (|s8_diff_ff[bpc_pkg::DIFF_W-1:P_TOP]);
   assign t_top  = s8_data_ff.temp_f[bpc_pkg::TEMP_W-1:bpc_pkg::TEMP_OUT_W-1];
   assign t_ok   = (&t_top) || !(|t_top);
   assign t_neg  = s8_data_ff.temp_f[bpc_pkg::TEMP_W-1];

   always_comb begin
      if (p_neg) begin
         s9_rsp_in.pressure_pa = '0;
      end else if (p_over) begin
         s9_rsp_in.pressure_pa = bpc_pkg::PRESS_W'(bpc_pkg::PRESS_MAX);
      end else begin
         s9_rsp_in.pressure_pa = s8_diff_ff[P_TOP-1:bpc_pkg::PRESS_SHIFT_LO];
      end
      if (t_ok) begin
         s9_rsp_in.temperature_centi = s8_data_ff.temp_f[bpc_pkg::TEMP_OUT_W-1:0];
      end else if (t_neg) begin
         s9_rsp_in.temperature_centi = {1'b1, {(bpc_pkg::TEMP_OUT_W-1){1'b0}}};
      end else begin
         s9_rsp_in.temperature_centi = {1'b0, {(bpc_pkg::TEMP_OUT_W-1){1'b1}}};
      end
      s9_rsp_in.low_temp_applied = s8_data_ff.low;
      s9_rsp_in.saturated        = !t_ok || p_neg || p_over;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else begin
         if (s6_en) s6_valid_ff <= in_valid;
         if (s7_en) s7_valid_ff <= s6_valid_ff;
         if (s8_en) s8_valid_ff <= s7_valid_ff;
         if (s9_en) s9_valid_ff <= s8_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s6_en) begin
         s6_pl_ff   <= s6_pl_in;
         s6_ph_ff   <= s6_ph_in;
         s6_data_ff <= in_data;
      end
      if (s7_en) begin
         s7_prod_ff <= s7_prod_in;
         s7_data_ff <= s6_data_ff;
      end
      if (s8_en) begin
         s8_diff_ff <= s8_diff_in;
         s8_data_ff <= s7_data_ff;
      end
      if (s9_en) begin
         s9_rsp_ff <= s9_rsp_in;
      end
   end

   assign out_valid = s9_valid_ff;
   assign out_data  = s9_rsp_ff;

   `BPC_ASSERT(a_warm_temp_floor, clock, reset, out_valid && !out_data.low_temp_applied |-> out_data.temperature_centi >= 16'(bpc_pkg::TEMP_REF_CENTI), "warm result below reference temperature")
   `BPC_ASSERT_NEXT(a_neg_pressure_clamp, clock, reset, s9_en && s8_valid_ff && s8_diff_ff[bpc_pkg::DIFF_W-1], out_data.saturated && out_data.pressure_pa == '0, "negative pressure not clamped to zero")

endmodule
